/* src/tukey_fence_outlier_scorer_unit_assert.svh */
// Assertion macros for the Tukey fence outlier scorer.
// Assertions are active in simulation only; synthesis sees empty bodies.
`ifndef TUKEY_FENCE_OUTLIER_SCORER_UNIT_ASSERT_SVH
`define TUKEY_FENCE_OUTLIER_SCORER_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define TFO_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("tfo assertion failed");
`define TFO_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("tfo assertion failed");
`else
`define TFO_ASSERT(label, clk, rst, prop)
`define TFO_ASSERT_ALWAYS(label, clk, prop)
`endif
`endif

/* src/tfo_pkg.sv */
// Shared types, constants and helpers of the Tukey fence outlier scorer.
// Has no dependencies; the files that use it refer to it by scoped names.
package tfo_pkg;

  localparam int MAX_LEN      = 64;
  localparam int SAMPLE_WIDTH = 32;
  localparam int ADDR_W       = $clog2(MAX_LEN);
  localparam int CNT_W        = $clog2(MAX_LEN + 1);
  localparam int PCT_W        = 16;
  localparam int GAIN_W       = 16;
  localparam int SCORE_W      = 58;
  localparam int STATUS_W     = 2;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 16;
  // Quantiles and fences carry nine fractional bits.
  localparam int Q_W          = SAMPLE_WIDTH + 9;
  localparam int PROD_W       = Q_W + GAIN_W;
  localparam int F_W          = Q_W + 10;
  localparam int S_W          = F_W + 2;

  localparam logic [PCT_W-1:0] PCT_MIN = PCT_W'(1311);
  localparam logic [PCT_W-1:0] PCT_MAX = PCT_W'(64225);
  localparam logic [CNT_W-1:0] MIN_SERIES = CNT_W'(4);
  localparam logic [CNT_W-1:0] MAX_COUNT  = CNT_W'(MAX_LEN);

  localparam logic [PCT_W-1:0]  LOW_PCT_RESET  = PCT_W'(16384);
  localparam logic [PCT_W-1:0]  HIGH_PCT_RESET = PCT_W'(49152);
  localparam logic [GAIN_W-1:0] GAIN_RESET     = GAIN_W'(384);

  localparam logic [CFG_IDX_W-1:0] REG_LOW_PCT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HIGH_PCT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN     = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_TOO_FEW   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_TOO_MANY  = 2'd2;
  localparam logic [STATUS_W-1:0] ST_MISORDER  = 2'd3;

  typedef struct packed {
    logic [PCT_W-1:0]  low_pct;
    logic [PCT_W-1:0]  high_pct;
    logic [GAIN_W-1:0] gain;
  } cfg_t;

  // One classified item handed from the front to the back.
  typedef struct packed {
    logic signed [SAMPLE_WIDTH-1:0] sample;
    logic                           eos;
    logic                           drop;
    logic [ADDR_W-1:0]              slot;
    logic [CNT_W-1:0]               len;
    logic [STATUS_W-1:0]            status;
  } entry_t;

  function automatic logic [PCT_W-1:0] clamp_pct(input logic [PCT_W-1:0] p);
    logic [PCT_W-1:0] r;
    r = p;
    if (p < PCT_MIN) r = PCT_MIN;
    else if (p > PCT_MAX) r = PCT_MAX;
    return r;
  endfunction

endpackage

/* src/tfo_in_if.sv */
// Input channel of the outlier scorer: valid/ready plus one sample.
// Depends on tfo_pkg for widths.
interface tfo_in_if;
  logic                                    valid;
  logic                                    ready;
  logic signed [tfo_pkg::SAMPLE_WIDTH-1:0] sample;
  logic                                    end_of_series;
  modport source (output valid, sample, end_of_series, input ready);
  modport sink (input valid, sample, end_of_series, output ready);
endinterface

/* src/tfo_out_if.sv */
// Output channel of the outlier scorer: valid/ready plus one score result.
// Depends on tfo_pkg for widths.
interface tfo_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [tfo_pkg::SCORE_W-1:0]  score;
  logic [tfo_pkg::STATUS_W-1:0]        status;
  logic                                final_result;
  modport source (output valid, score, status, final_result, input ready);
  modport sink (input valid, score, status, final_result, output ready);
endinterface

/* src/tfo_ram.sv */
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module tfo_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

/* src/tfo_front.sv */
// Front part: accepts samples, counts the series, classifies each item and
// queues it for the back part. Depends on tfo_pkg and tfo_in_if.
`include "tukey_fence_outlier_scorer_unit_assert.svh"
module tfo_front (
  input  logic             clk,
  input  logic             rst,
  tfo_in_if.sink           in_ch,
  input  tfo_pkg::cfg_t    cfg,
  output tfo_pkg::entry_t  q_entry,
  output logic             q_valid,
  input  logic             q_ready
);
  localparam int QD   = 4;
  localparam int QP_W = $clog2(QD);
  localparam int QC_W = $clog2(QD + 1);

  tfo_pkg::entry_t             fifo [QD];
  logic [QP_W-1:0]             wp, rp;
  logic [QC_W-1:0]             fill;
  logic [tfo_pkg::CNT_W-1:0]   count;
  logic                        ovf;
  logic                        push, pop, full;
  tfo_pkg::entry_t             ent;
  logic [tfo_pkg::PCT_W-1:0]   plo, phi;

  assign full        = (fill == QC_W'(QD));
  assign in_ch.ready = !full;
  assign push        = in_ch.valid && in_ch.ready;
  assign q_valid     = (fill != '0);
  assign pop         = q_valid && q_ready;
  assign q_entry     = fifo[rp];

  always_comb begin
    plo          = tfo_pkg::clamp_pct(cfg.low_pct);
    phi          = tfo_pkg::clamp_pct(cfg.high_pct);
    ent.sample   = in_ch.sample;
    ent.eos      = in_ch.end_of_series;
    ent.drop     = (count >= tfo_pkg::MAX_COUNT);
    ent.slot     = count[tfo_pkg::ADDR_W-1:0];
    ent.len      = ent.drop ? count : count + 1'b1;
    // Misordered percentiles win over a short series, which wins over overflow.
    priority if (plo > phi) ent.status = tfo_pkg::ST_MISORDER;
    else if (ent.len < tfo_pkg::MIN_SERIES) ent.status = tfo_pkg::ST_TOO_FEW;
    else if (ovf || ent.drop) ent.status = tfo_pkg::ST_TOO_MANY;
    else ent.status = tfo_pkg::ST_OK;
  end

  always_ff @(posedge clk) begin
    if (push) begin
      fifo[wp] <= ent;
    end
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      fill  <= '0;
      count <= '0;
      ovf   <= 1'b0;
    end else begin
      if (push) begin
        wp <= wp + 1'b1;
        if (in_ch.end_of_series) begin
          count <= '0;
          ovf   <= 1'b0;
        end else if (ent.drop) begin
          ovf <= 1'b1;
        end else begin
          count <= count + 1'b1;
        end
      end
      if (pop) begin
        rp <= rp + 1'b1;
      end
      fill <= fill + QC_W'(push) - QC_W'(pop);
    end
  end

  `TFO_ASSERT(a_count_bound, clk, rst, count <= tfo_pkg::MAX_COUNT)
  `TFO_ASSERT(a_ovf_only_full, clk, rst, ovf |-> count == tfo_pkg::MAX_COUNT)
  `TFO_ASSERT(a_fill_bound, clk, rst, fill <= QC_W'(QD))
endmodule

/* src/tfo_back.sv */
// Back part: insertion sort into the sorted store, quantiles, fences and
// the scoring pass. Depends on tfo_pkg, tfo_out_if and tfo_ram.
`include "tukey_fence_outlier_scorer_unit_assert.svh"
module tfo_back (
  input  logic             clk,
  input  logic             rst,
  input  tfo_pkg::cfg_t    cfg,
  input  tfo_pkg::entry_t  q_entry,
  input  logic             q_valid,
  output logic             q_ready,
  tfo_out_if.source        out_ch
);
  localparam int DW = tfo_pkg::SAMPLE_WIDTH;
  localparam int AW = tfo_pkg::ADDR_W;
  localparam int CW = tfo_pkg::CNT_W;
  localparam int QW = tfo_pkg::Q_W;
  localparam int FW = tfo_pkg::F_W;
  localparam int SW = tfo_pkg::S_W;
  localparam int PW = tfo_pkg::PCT_W;

  typedef enum logic [14:0] {
    S_IDLE    = 15'h0001,
    S_INS_RD  = 15'h0002,
    S_INS_CMP = 15'h0004,
    S_INS_FIN = 15'h0008,
    S_POST    = 15'h0010,
    S_Q_RD0   = 15'h0020,
    S_Q_RD1   = 15'h0040,
    S_Q_CAP   = 15'h0080,
    S_F_SUB   = 15'h0100,
    S_F_MUL   = 15'h0200,
    S_F_ADD   = 15'h0400,
    S_E_RD    = 15'h0800,
    S_E_CALC  = 15'h1000,
    S_E_WAIT  = 15'h2000,
    S_ERR     = 15'h4000
  } state_t;

  state_t                       state, state_next;
  logic signed [DW-1:0]         x;
  logic [AW-1:0]                j;
  logic                         eos;
  logic [CW-1:0]                len;
  logic [tfo_pkg::STATUS_W-1:0] status;
  logic                         qsel, whole_r;
  logic signed [DW-1:0]         d0;
  logic signed [QW-1:0]         q_lo, q_hi;
  logic [QW-1:0]                iqr;
  logic [tfo_pkg::PROD_W-1:0]   prod;
  logic signed [FW-1:0]         lo_fence, hi_fence;
  logic [AW-1:0]                ei;

  // Sorted and original stores.
  logic          s_we, o_we;
  logic [AW-1:0] s_waddr, s_raddr, o_raddr;
  logic [DW-1:0] s_wdata, s_rdata, o_rdata;

  tfo_ram #(.WIDTH(DW), .DEPTH(tfo_pkg::MAX_LEN)) u_sorted (
    .clk(clk), .we(s_we), .waddr(s_waddr), .wdata(s_wdata),
    .raddr(s_raddr), .rdata(s_rdata)
  );
  tfo_ram #(.WIDTH(DW), .DEPTH(tfo_pkg::MAX_LEN)) u_orig (
    .clk(clk), .we(o_we), .waddr(q_entry.slot), .wdata(q_entry.sample),
    .raddr(o_raddr), .rdata(o_rdata)
  );

  // Quantile index from len * percentile.
  logic [PW-1:0]    pct;
  logic [CW+PW-1:0] pos;
  logic [CW-1:0]    ip, i0, i1;
  logic             whole;
  logic             greater;

  always_comb begin
    pct   = tfo_pkg::clamp_pct(qsel ? cfg.high_pct : cfg.low_pct);
    pos   = (CW+PW)'(len) * (CW+PW)'(pct);
    ip    = pos[CW+PW-1:PW];
    whole = (pos[PW-1:0] == '0);
    if (whole) begin
      i0 = (ip == '0) ? '0 : ip - 1'b1;
      if (i0 + 1'b1 >= len) i0 = len - CW'(2);
      i1 = i0 + 1'b1;
    end else begin
      i0 = (ip >= len) ? len - 1'b1 : ip;
      i1 = i0;
    end
  end

  assign greater = ($signed(s_rdata) > x);
  assign q_ready = (state == S_IDLE);

  always_comb begin
    s_we    = 1'b0;
    s_waddr = j;
    s_wdata = x;
    s_raddr = j - 1'b1;
    o_we    = 1'b0;
    o_raddr = ei;
    unique case (state)
      S_IDLE: begin
        o_we    = q_valid && !q_entry.drop;
        s_we    = q_valid && !q_entry.drop && (q_entry.slot == '0);
        s_waddr = '0;
        s_wdata = q_entry.sample;
      end
      S_INS_CMP: begin
        s_we    = 1'b1;
        s_wdata = greater ? s_rdata : x;
      end
      S_INS_FIN: begin
        s_we    = 1'b1;
        s_waddr = '0;
      end
      S_Q_RD0: s_raddr = i0[AW-1:0];
      S_Q_RD1: s_raddr = i1[AW-1:0];
      default: ;
    endcase
  end

  // Score of one sample; the range is far inside the output width.
  logic signed [QW-1:0]   xs;
  logic signed [FW:0]     a, b;
  logic signed [SW-1:0]   s;

  always_comb begin
    xs = QW'($signed(o_rdata)) <<< 9;
    a  = (FW+1)'(xs) - (FW+1)'(lo_fence);
    b  = (FW+1)'(xs) - (FW+1)'(hi_fence);
    s  = (a[FW] ? SW'(a) : '0) + ((!b[FW] && b != '0) ? SW'(b) : '0);
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (q_valid) begin
          if (q_entry.drop || q_entry.slot == '0) state_next = S_POST;
          else state_next = S_INS_RD;
        end
      end
      S_INS_RD:  state_next = S_INS_CMP;
      S_INS_CMP: begin
        if (!greater) state_next = S_POST;
        else if (j == AW'(1)) state_next = S_INS_FIN;
        else state_next = S_INS_RD;
      end
      S_INS_FIN: state_next = S_POST;
      S_POST: begin
        if (!eos) state_next = S_IDLE;
        else if (status != tfo_pkg::ST_OK) state_next = S_ERR;
        else state_next = S_Q_RD0;
      end
      S_Q_RD0: state_next = S_Q_RD1;
      S_Q_RD1: state_next = S_Q_CAP;
      S_Q_CAP: state_next = qsel ? S_F_SUB : S_Q_RD0;
      S_F_SUB: state_next = S_F_MUL;
      S_F_MUL: state_next = S_F_ADD;
      S_F_ADD: state_next = S_E_RD;
      S_E_RD:  state_next = S_E_CALC;
      S_E_CALC: state_next = S_E_WAIT;
      S_E_WAIT: begin
        if (out_ch.ready) begin
          state_next = (CW'(ei) + 1'b1 == len) ? S_IDLE : S_E_RD;
        end
      end
      S_ERR: if (out_ch.ready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // k*IQR in Q.9 spans the full product width less the eight dropped bits.
  logic [tfo_pkg::PROD_W-9:0] kiqr;
  assign kiqr = (tfo_pkg::PROD_W-8)'((prod + tfo_pkg::PROD_W'(128)) >> 8);

  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        x      <= q_entry.sample;
        j      <= q_entry.slot;
        eos    <= q_entry.eos;
        len    <= q_entry.len;
        status <= q_entry.status;
      end
      S_INS_CMP: if (greater) j <= j - 1'b1;
      S_POST: begin
        qsel <= 1'b0;
        ei   <= '0;
      end
      S_Q_RD0: whole_r <= whole;
      S_Q_RD1: d0 <= s_rdata;
      S_Q_CAP: begin
        if (qsel) begin
          q_hi <= whole_r ? (QW'((DW+1)'(d0) + (DW+1)'($signed(s_rdata))) <<< 8)
                          : (QW'(d0) <<< 9);
        end else begin
          q_lo <= whole_r ? (QW'((DW+1)'(d0) + (DW+1)'($signed(s_rdata))) <<< 8)
                          : (QW'(d0) <<< 9);
        end
        qsel <= 1'b1;
      end
      S_F_SUB: iqr <= QW'(q_hi - q_lo);
      S_F_MUL: prod <= tfo_pkg::PROD_W'(iqr) * tfo_pkg::PROD_W'(cfg.gain);
      S_F_ADD: begin
        lo_fence <= FW'(q_lo) - FW'(kiqr);
        hi_fence <= FW'(q_hi) + FW'(kiqr);
      end
      S_E_WAIT: if (out_ch.ready) ei <= ei + 1'b1;
      default: ;
    endcase

    if (state == S_E_CALC) begin
      out_ch.score        <= tfo_pkg::SCORE_W'(s);
      out_ch.status       <= tfo_pkg::ST_OK;
      out_ch.final_result <= (CW'(ei) + 1'b1 == len);
    end else if (state == S_POST) begin
      out_ch.score        <= '0;
      out_ch.status       <= status;
      out_ch.final_result <= 1'b1;
    end

    if (rst) begin
      state        <= S_IDLE;
      out_ch.valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_E_CALC ||
          (state == S_POST && eos && status != tfo_pkg::ST_OK)) begin
        out_ch.valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_ch.valid <= 1'b0;
      end
    end
  end

  `TFO_ASSERT(a_valid_states, clk, rst,
    out_ch.valid |-> (state == S_E_WAIT || state == S_ERR))
  `TFO_ASSERT(a_err_result, clk, rst,
    (out_ch.valid && out_ch.status != tfo_pkg::ST_OK) |->
      (out_ch.final_result && out_ch.score == '0))
  `TFO_ASSERT(a_ins_index, clk, rst, (state == S_INS_CMP) |-> (j != '0))
endmodule

/* src/tukey_fence_outlier_scorer_unit.sv */
// Top level of the Tukey fence outlier scorer: configuration registers,
// front classifier and back engine. Depends on tfo_pkg, the interfaces,
// tfo_front and tfo_back.
//
// Channel   Dir  Payload                              Handshake
// in_ch     in   sample, end_of_series                valid/ready
// out_ch    out  score, status, final_result          valid/ready
// cfg       in   cfg_index, cfg_data                  cfg_we, no wait
//
// In the back, a sample is inserted by reading each sorted entry in turn and
// moving it up while it is greater, until its place or the front is found;
// the back takes the next sample only when it is idle again.
// At end of series the back finds the quantiles and fences, then scores the
// samples, waiting out output stalls. An error series ends in one result.
// Reset is synchronous and clears control state only; the stores need none.
// A four-entry queue between front and back lets input and output stall apart.
module tukey_fence_outlier_scorer_unit (
  input  logic                            clk,
  input  logic                            rst,
  tfo_in_if.sink                          in_ch,
  tfo_out_if.source                       out_ch,
  input  logic                            cfg_we,
  input  logic [tfo_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [tfo_pkg::CFG_DATA_W-1:0]  cfg_data
);
  tfo_pkg::cfg_t   cfg;
  tfo_pkg::entry_t q_entry;
  logic            q_valid, q_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.low_pct  <= tfo_pkg::LOW_PCT_RESET;
      cfg.high_pct <= tfo_pkg::HIGH_PCT_RESET;
      cfg.gain     <= tfo_pkg::GAIN_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        tfo_pkg::REG_LOW_PCT:  cfg.low_pct  <= cfg_data;
        tfo_pkg::REG_HIGH_PCT: cfg.high_pct <= cfg_data;
        tfo_pkg::REG_GAIN:     cfg.gain     <= cfg_data;
        default: ;
      endcase
    end
  end

  tfo_front u_front (
    .clk(clk), .rst(rst), .in_ch(in_ch), .cfg(cfg),
    .q_entry(q_entry), .q_valid(q_valid), .q_ready(q_ready)
  );

  tfo_back u_back (
    .clk(clk), .rst(rst), .cfg(cfg),
    .q_entry(q_entry), .q_valid(q_valid), .q_ready(q_ready),
    .out_ch(out_ch)
  );
endmodule
